FILE: design/srrc_pkg.sv
// Shared types, codes and constants for the stream resync retry controller.
package srrc_pkg;

    localparam int unsigned WAIT_W     = 22;
    localparam int unsigned BUDGET_W   = 10;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DEADLINE_W = TIME_W + 1;

    localparam logic [WAIT_W-1:0]   WAIT_MAX     = 22'd3600000;
    localparam logic [WAIT_W-1:0]   WAIT_RESET   = 22'd1000;
    localparam logic [BUDGET_W-1:0] BUDGET_MAX   = 10'd1000;
    localparam logic [BUDGET_W-1:0] BUDGET_RESET = 10'd3;
    localparam logic [BUDGET_W-1:0] COUNT_MAX    = 10'd1023;

    localparam logic [1:0] OP_REPEAT  = 2'd0;
    localparam logic [1:0] OP_ACCEPT  = 2'd1;
    localparam logic [1:0] OP_POLL    = 2'd2;
    localparam logic [1:0] OP_REBUILT = 2'd3;

    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_IDR     = 2'd1;
    localparam logic [1:0] ACT_REBUILD = 2'd2;

    localparam logic [1:0] CODE_RUNNING   = 2'd0;
    localparam logic [1:0] CODE_WAITING   = 2'd1;
    localparam logic [1:0] CODE_RECOVERY  = 2'd2;
    localparam logic [1:0] CODE_EXHAUSTED = 2'd3;

    localparam logic REG_WAIT   = 1'b0;
    localparam logic REG_BUDGET = 1'b1;

    typedef enum logic [3:0] {
        PH_RUNNING   = 4'b0001,
        PH_WAITING   = 4'b0010,
        PH_RECOVERY  = 4'b0100,
        PH_EXHAUSTED = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [1:0]        op;
        logic [TIME_W-1:0] now_ms;
        logic              is_idr;
        logic              rep_frame;
        logic              new_content;
    } evt_t;

    typedef struct packed {
        logic       accept;
        logic [1:0] action;
        logic [1:0] phase_now;
    } res_t;

    typedef struct packed {
        logic [WAIT_W-1:0]   wait_timeout_ms;
        logic [BUDGET_W-1:0] retry_budget;
    } cfg_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        case (ph)
            PH_RUNNING:   code = CODE_RUNNING;
            PH_WAITING:   code = CODE_WAITING;
            PH_RECOVERY:  code = CODE_RECOVERY;
            PH_EXHAUSTED: code = CODE_EXHAUSTED;
            default:      code = CODE_RUNNING;
        endcase
        return code;
    endfunction

endpackage

FILE: design/srrc_if.sv
// Stream interfaces for event input and result output.
interface srrc_evt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic        is_idr;
    logic        rep_frame;
    logic        new_content;

    modport source(output valid, op, now_ms, is_idr, rep_frame, new_content,
                   input ready);
    modport sink(input valid, op, now_ms, is_idr, rep_frame, new_content,
                 output ready);
endinterface

interface srrc_res_if;
    logic       valid;
    logic       ready;
    logic       accept;
    logic [1:0] action;
    logic [1:0] phase_now;

    modport source(output valid, accept, action, phase_now, input ready);
    modport sink(input valid, accept, action, phase_now, output ready);
endinterface

FILE: design/srrc_cfg.sv
// APB configuration registers with range check on write.
module srrc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output srrc_pkg::cfg_t      cfg
);

    logic [srrc_pkg::WAIT_W-1:0]   wait_reg;
    logic [srrc_pkg::WAIT_W-1:0]   wait_next;
    logic [srrc_pkg::BUDGET_W-1:0] budget_reg;
    logic [srrc_pkg::BUDGET_W-1:0] budget_next;
    logic                          wr_en;
    logic [srrc_pkg::WAIT_W-1:0]   wdata_wait;
    logic [srrc_pkg::BUDGET_W-1:0] wdata_budget;

    assign pready       = 1'b1;
    assign wr_en        = psel && penable && pwrite;
    assign wdata_wait   = pwdata[srrc_pkg::WAIT_W-1:0];
    assign wdata_budget = pwdata[srrc_pkg::BUDGET_W-1:0];

    always_comb
    begin
        wait_next   = wait_reg;
        budget_next = budget_reg;
        if (wr_en)
        begin
            case (paddr[2])
                srrc_pkg::REG_WAIT:
                begin
                    if (wdata_wait != '0 && wdata_wait <= srrc_pkg::WAIT_MAX)
                        wait_next = wdata_wait;
                end
                srrc_pkg::REG_BUDGET:
                begin
                    if (wdata_budget != '0 && wdata_budget <= srrc_pkg::BUDGET_MAX)
                        budget_next = wdata_budget;
                end
                default:
                begin
                    wait_next = wait_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg   <= srrc_pkg::WAIT_RESET;
            budget_reg <= srrc_pkg::BUDGET_RESET;
        end
        else
        begin
            wait_reg   <= wait_next;
            budget_reg <= budget_next;
        end
    end

    always_comb
    begin
        case (paddr[2])
            srrc_pkg::REG_WAIT:   prdata = {10'd0, wait_reg};
            srrc_pkg::REG_BUDGET: prdata = {22'd0, budget_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.wait_timeout_ms = wait_reg;
    assign cfg.retry_budget    = budget_reg;

endmodule

FILE: design/srrc_step.sv
// Phase state, deadline and retry counter with the per-event update logic.
module srrc_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           step_en,
    input  srrc_pkg::evt_t evt,
    input  srrc_pkg::cfg_t cfg,
    output srrc_pkg::res_t res
);

    srrc_pkg::phase_t                  phase_reg;
    srrc_pkg::phase_t                  phase_next;
    srrc_pkg::phase_t                  phase_chk;
    logic [srrc_pkg::DEADLINE_W-1:0]   deadline_reg;
    logic [srrc_pkg::DEADLINE_W-1:0]   deadline_next;
    logic [srrc_pkg::DEADLINE_W-1:0]   now_ext;
    logic [srrc_pkg::DEADLINE_W-1:0]   start_deadline;
    logic [srrc_pkg::BUDGET_W-1:0]     retry_count_reg;
    logic [srrc_pkg::BUDGET_W-1:0]     retry_count_next;
    logic [srrc_pkg::BUDGET_W-1:0]     retry_inc;
    logic                              accept;
    logic [1:0]                        action;

    assign now_ext        = {1'b0, evt.now_ms};
    assign start_deadline = now_ext +
        {{(srrc_pkg::DEADLINE_W - srrc_pkg::WAIT_W){1'b0}}, cfg.wait_timeout_ms};
    assign retry_inc      = (retry_count_reg == srrc_pkg::COUNT_MAX) ?
                            retry_count_reg : retry_count_reg + 1'b1;

    always_comb
    begin
        phase_chk = phase_reg;
        if ((evt.op == srrc_pkg::OP_ACCEPT || evt.op == srrc_pkg::OP_POLL) &&
            phase_reg == srrc_pkg::PH_WAITING && now_ext >= deadline_reg)
            phase_chk = srrc_pkg::PH_RECOVERY;
    end

    always_comb
    begin
        phase_next       = phase_chk;
        deadline_next    = deadline_reg;
        retry_count_next = retry_count_reg;
        accept           = 1'b0;
        action           = srrc_pkg::ACT_NONE;
        case (evt.op)
            srrc_pkg::OP_REPEAT:
            begin
                if (phase_reg == srrc_pkg::PH_RUNNING)
                begin
                    phase_next    = srrc_pkg::PH_WAITING;
                    deadline_next = start_deadline;
                end
            end
            srrc_pkg::OP_ACCEPT:
            begin
                if (phase_chk == srrc_pkg::PH_RUNNING)
                    accept = evt.new_content && !evt.rep_frame;
                else if (phase_chk == srrc_pkg::PH_WAITING && evt.is_idr &&
                         !evt.rep_frame && evt.new_content)
                begin
                    phase_next       = srrc_pkg::PH_RUNNING;
                    retry_count_next = '0;
                    deadline_next    = '0;
                    accept           = 1'b1;
                end
            end
            srrc_pkg::OP_POLL:
            begin
                if (phase_chk == srrc_pkg::PH_RECOVERY)
                begin
                    retry_count_next = retry_inc;
                    if (retry_inc < cfg.retry_budget)
                    begin
                        phase_next    = srrc_pkg::PH_WAITING;
                        deadline_next = start_deadline;
                        action        = srrc_pkg::ACT_IDR;
                    end
                    else if (retry_inc == cfg.retry_budget)
                    begin
                        phase_next    = srrc_pkg::PH_WAITING;
                        deadline_next = start_deadline;
                        action        = srrc_pkg::ACT_REBUILD;
                    end
                    else
                    begin
                        phase_next    = srrc_pkg::PH_EXHAUSTED;
                        deadline_next = '0;
                    end
                end
            end
            srrc_pkg::OP_REBUILT:
            begin
                phase_next    = srrc_pkg::PH_WAITING;
                deadline_next = start_deadline;
            end
            default:
            begin
                phase_next = phase_chk;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= srrc_pkg::PH_RUNNING;
            deadline_reg    <= '0;
            retry_count_reg <= '0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            deadline_reg    <= deadline_next;
            retry_count_reg <= retry_count_next;
        end
    end

    assign res.accept    = accept;
    assign res.action    = action;
    assign res.phase_now = srrc_pkg::phase_code(phase_next);

    a_exhausted_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == srrc_pkg::PH_EXHAUSTED &&
        !(step_en && evt.op == srrc_pkg::OP_REBUILT)
        |=> phase_reg == srrc_pkg::PH_EXHAUSTED)
        else $error("exhausted phase left without session rebuild");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> $stable(phase_reg) && $stable(retry_count_reg))
        else $error("state changed without an event");

    a_rebuild_at_budget: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && action == srrc_pkg::ACT_REBUILD
        |=> retry_count_reg == $past(cfg.retry_budget) &&
            phase_reg == srrc_pkg::PH_WAITING)
        else $error("rebuild issued off budget");

    a_action_from_recovery: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && action != srrc_pkg::ACT_NONE
        |=> retry_count_reg != '0)
        else $error("recovery action without a counted retry");

endmodule

FILE: design/stream_resync_retry_controller_unit.sv
// Top level: event input register, step logic, result register and APB port.
// An event transfer reaches its result transfer through the input register and then the result register.
// Throughput: one event per cycle while the result side does not stall; the phase/deadline/retry update never holds it.
// Stalls on the result side back up through the input register without loss.
// Reset (rst_n low, async): phase running, deadline and retry count zero,
// wait timeout 1000 ms, retry budget 3, both stream stages empty.
module stream_resync_retry_controller_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    srrc_evt_if.sink    evt,
    srrc_res_if.source  res
);

    srrc_pkg::cfg_t cfg;
    srrc_pkg::evt_t evt_reg;
    srrc_pkg::evt_t evt_next;
    srrc_pkg::res_t res_reg;
    srrc_pkg::res_t step_res;
    logic           evt_valid_reg;
    logic           res_valid_reg;
    logic           advance;
    logic           evt_take;

    srrc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance   = evt_valid_reg && (!res_valid_reg || res.ready);
    assign evt.ready = !evt_valid_reg || advance;
    assign evt_take  = evt.valid && evt.ready;

    assign evt_next.op          = evt.op;
    assign evt_next.now_ms      = evt.now_ms;
    assign evt_next.is_idr      = evt.is_idr;
    assign evt_next.rep_frame   = evt.rep_frame;
    assign evt_next.new_content = evt.new_content;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (evt.ready)
            evt_valid_reg <= evt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (evt_take)
            evt_reg <= evt_next;
    end

    srrc_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .evt     (evt_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (!res_valid_reg || res.ready)
            res_valid_reg <= evt_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= step_res;
    end

    assign res.valid     = res_valid_reg;
    assign res.accept    = res_reg.accept;
    assign res.action    = res_reg.action;
    assign res.phase_now = res_reg.phase_now;

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res.ready |=> res_valid_reg)
        else $error("pending result dropped");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("processed event produced no result");

    a_stall_holds_event: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && !advance |=> evt_valid_reg && $stable(evt_reg))
        else $error("stalled event lost");

endmodule
